// ===== rtl/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// rls_pkg
// shared types, constants and codes of the region label statistics block
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int NUM_REGIONS = 256;
  localparam int IDX_W       = $clog2(NUM_REGIONS);
  localparam int LABEL_W     = 9;
  localparam int MAX_VOXELS  = 16777216;
  localparam logic [24:0] SIG_SAT = 25'd33554431;
  localparam logic [8:0]  REGION_COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACC   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_CLEAR = 2'd0,
    K_ACC   = 2'd1,
    K_READ  = 2'd2,
    K_NOP   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    status_t           status;
    logic [IDX_W-1:0]  idx;
    logic signed [15:0] sample;
  } cmd_t;

  typedef struct packed {
    logic signed [39:0] sum;
    logic [24:0]        cnt;
    logic [54:0]        sq;
    logic signed [15:0] mn;
    logic signed [15:0] mx;
  } acc_t;

  typedef struct packed {
    acc_t all;
    acc_t nz;
  } entry_t;

  localparam acc_t ACC_RESET = '{sum: '0, cnt: '0, sq: '0,
                                 mn: 16'sh7fff, mx: 16'sh8000};

  typedef struct packed {
    logic               start;
    logic               sigma;
    logic [24:0]        cnt;
    logic signed [39:0] sum;
    logic [54:0]        sq;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] value;
  } arith_rsp_t;

  typedef struct packed {
    logic signed [15:0] nonzero_maximum;
    logic signed [15:0] nonzero_minimum;
    logic [24:0]        nonzero_std_dev;
    logic signed [23:0] nonzero_mean;
    logic signed [39:0] nonzero_sum;
    logic [24:0]        nonzero_count;
    logic signed [15:0] maximum;
    logic signed [15:0] minimum;
    logic [24:0]        std_dev;
    logic signed [23:0] mean_value;
    logic [24:0]        voxel_count;
    status_t            status;
  } result_t;

endpackage

// ===== rtl/rls_front.sv =====
// ----------------------------------------------------------------------------
// rls_front
// accepts items, checks labels against region_count, queues commands
// ----------------------------------------------------------------------------
module rls_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [8:0]        region_label,
  input  logic signed [15:0] sample,
  input  logic              cfg_valid,
  input  logic [8:0]        cfg_data,
  output logic              q_valid,
  output rls_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);

  logic [8:0]    region_count;
  logic [8:0]    lim;
  logic          in_range;
  rls_pkg::cmd_t cmd;
  rls_pkg::cmd_t fifo [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= rls_pkg::REGION_COUNT_RESET;
    end else if (cfg_valid) begin
      region_count <= cfg_data;
    end
  end

  always_comb begin
    lim = (region_count > 9'(rls_pkg::NUM_REGIONS)) ? 9'(rls_pkg::NUM_REGIONS)
                                                     : region_count;
    in_range   = (region_label != '0) && (region_label <= lim);
    cmd.idx    = rls_pkg::IDX_W'(region_label - 9'd1);
    cmd.sample = sample;
    cmd.status = rls_pkg::ST_OK;
    cmd.kind   = rls_pkg::K_NOP;
    unique case (rls_pkg::opcode_t'(opcode))
      rls_pkg::OP_CLEAR: cmd.kind = rls_pkg::K_CLEAR;
      rls_pkg::OP_ACC: begin
        if (region_label == '0) begin
          cmd.kind = rls_pkg::K_NOP;
        end else if (!in_range) begin
          cmd.status = rls_pkg::ST_RANGE;
        end else begin
          cmd.kind = rls_pkg::K_ACC;
        end
      end
      rls_pkg::OP_READ: begin
        if (!in_range) begin
          cmd.status = rls_pkg::ST_RANGE;
        end else begin
          cmd.kind = rls_pkg::K_READ;
        end
      end
      default: cmd.kind = rls_pkg::K_NOP;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/rls_arith.sv =====
// ----------------------------------------------------------------------------
// rls_arith
// iterative mean and deviation unit: shift-add multiply, restoring divide,
// digit-by-digit square root
// ----------------------------------------------------------------------------
module rls_arith (
  input  logic                clk,
  input  logic                rst,
  input  rls_pkg::arith_req_t req,
  output rls_pkg::arith_rsp_t rsp
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_SQRT = 4'b1000
  } astate_t;

  astate_t     state;
  logic        done_r;
  logic [24:0] value_r;
  logic        sigma;
  logic        neg;
  logic        sub_phase;
  logic [6:0]  steps;
  logic [39:0] mag;
  logic [39:0] mag_c;
  logic [47:0] numer;
  logic [79:0] mcand;
  logic [39:0] mplier;
  logic [79:0] acc;
  logic [79:0] acc_next;
  logic [95:0] dividend;
  logic [49:0] m_div;
  logic [50:0] rem;
  logic [50:0] rem2;
  logic        ge;
  logic [49:0] dvd;
  logic [49:0] quo;
  logic [49:0] quo_next;
  logic [24:0] q_mean;
  logic [49:0] sqv;
  logic [26:0] sq_rem;
  logic [28:0] rt_rem;
  logic [28:0] trial;
  logic        rt_ge;
  logic [24:0] root;
  logic [24:0] root_next;

  assign rsp.done  = done_r;
  assign rsp.value = value_r;

  always_comb begin
    mag_c    = req.sum[39] ? 40'(-req.sum) : 40'(req.sum);
    numer    = {mag_c, 8'd0} + 48'(req.cnt >> 1);
    acc_next = acc;
    if (mplier[0]) begin
      acc_next = sub_phase ? (acc - mcand) : (acc + mcand);
    end
    dividend  = {acc_next, 16'd0};
    rem2      = {rem[49:0], dvd[49]};
    ge        = rem2 >= {1'b0, m_div};
    quo_next  = {quo[48:0], ge};
    q_mean    = quo_next[24:0];
    rt_rem    = {sq_rem, sqv[49:48]};
    trial     = {2'b00, root, 2'b01};
    rt_ge     = rt_rem >= trial;
    root_next = {root[23:0], rt_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= ((state == A_DIV) && (steps == 7'd1) && !sigma) ||
                ((state == A_SQRT) && (steps == 7'd1));
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            state <= req.sigma ? A_MUL : A_DIV;
          end
        end
        A_MUL: begin
          if (steps == 7'd1 && sub_phase) state <= A_DIV;
        end
        A_DIV: begin
          if (steps == 7'd1) begin
            state <= sigma ? A_SQRT : A_IDLE;
          end
        end
        A_SQRT: begin
          if (steps == 7'd1) begin
            state <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        if (req.start) begin
          sigma     <= req.sigma;
          neg       <= req.sum[39];
          mag       <= mag_c;
          quo       <= '0;
          acc       <= '0;
          sub_phase <= 1'b0;
          m_div     <= req.sigma ? (50'(req.cnt) * 50'(req.cnt - 25'd1)) : 50'(req.cnt);
          if (req.sigma) begin
            mcand  <= 80'(req.sq);
            mplier <= 40'(req.cnt);
            steps  <= 7'd25;
          end else begin
            rem   <= '0;
            dvd   <= 50'(numer);
            steps <= 7'd50;
          end
        end
      end
      A_MUL: begin
        acc <= acc_next;
        if (steps == 7'd1) begin
          if (!sub_phase) begin
            sub_phase <= 1'b1;
            mcand     <= 80'(mag);
            mplier    <= mag;
            steps     <= 7'd40;
          end else begin
            rem   <= 51'(dividend[95:50]);
            dvd   <= dividend[49:0];
            steps <= 7'd50;
          end
        end else begin
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          steps  <= steps - 7'd1;
        end
      end
      A_DIV: begin
        rem <= ge ? (rem2 - {1'b0, m_div}) : rem2;
        dvd <= dvd << 1;
        quo <= quo_next;
        if (steps == 7'd1 && sigma) begin
          sqv    <= quo_next;
          sq_rem <= '0;
          root   <= '0;
          steps  <= 7'd25;
        end else begin
          steps <= steps - 7'd1;
        end
        if (steps == 7'd1 && !sigma) begin
          value_r <= neg ? 25'(-q_mean) : q_mean;
        end
      end
      A_SQRT: begin
        sq_rem <= rt_ge ? 27'(rt_rem - trial) : rt_rem[26:0];
        root   <= root_next;
        sqv    <= sqv << 2;
        steps  <= steps - 7'd1;
        if (steps == 7'd1) begin
          value_r <= root_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/rls_back.sv =====
// ----------------------------------------------------------------------------
// rls_back
// executes queued commands against the per-region store and builds results
// ----------------------------------------------------------------------------
module rls_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  rls_pkg::cmd_t        q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rls_pkg::result_t     out_res
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_EXEC = 5'b00010,
    B_SET  = 5'b00100,
    B_MEAN = 5'b01000,
    B_SIG  = 5'b10000
  } bstate_t;

  bstate_t                     state;
  rls_pkg::entry_t             mem [rls_pkg::NUM_REGIONS];
  logic [rls_pkg::NUM_REGIONS-1:0] valid;
  rls_pkg::entry_t             rd_data;
  logic                        rd_valid;
  rls_pkg::cmd_t               cur;
  rls_pkg::entry_t             rec;
  rls_pkg::entry_t             upd;
  rls_pkg::entry_t             held;
  rls_pkg::acc_t               set_acc;
  rls_pkg::result_t            exec_res;
  logic                        sel;
  logic signed [31:0]          sq_prod;
  logic                        wr_en;
  logic                        clr_en;
  rls_pkg::arith_req_t         areq;
  rls_pkg::arith_rsp_t         arsp;
  logic [24:0]                 mean_v [2];
  logic [24:0]                 sig_v [2];
  logic                        set_done;
  logic [24:0]                 set_mean;
  logic [24:0]                 set_sig;

  rls_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  assign q_pop = (state == B_IDLE) && q_valid && !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data  <= mem[q_cmd.idx];
      rd_valid <= valid[q_cmd.idx];
      cur      <= q_cmd;
    end
  end

  always_comb begin
    rec     = rd_valid ? rd_data
                       : rls_pkg::entry_t'{all: rls_pkg::ACC_RESET, nz: rls_pkg::ACC_RESET};
    sq_prod = cur.sample * cur.sample;
    upd     = rec;
    if (rec.all.cnt < 25'(rls_pkg::MAX_VOXELS)) begin
      upd.all.sum = rec.all.sum + 40'(cur.sample);
      upd.all.cnt = rec.all.cnt + 25'd1;
      upd.all.sq  = rec.all.sq + 55'(unsigned'(sq_prod));
      if (cur.sample < rec.all.mn) upd.all.mn = cur.sample;
      if (cur.sample > rec.all.mx) upd.all.mx = cur.sample;
      if (cur.sample != '0) begin
        upd.nz.sum = rec.nz.sum + 40'(cur.sample);
        upd.nz.cnt = rec.nz.cnt + 25'd1;
        upd.nz.sq  = rec.nz.sq + 55'(unsigned'(sq_prod));
        if (cur.sample < rec.nz.mn) upd.nz.mn = cur.sample;
        if (cur.sample > rec.nz.mx) upd.nz.mx = cur.sample;
      end
    end
    wr_en  = (state == B_EXEC) && (cur.kind == rls_pkg::K_ACC);
    clr_en = (state == B_EXEC) && (cur.kind == rls_pkg::K_CLEAR);
    exec_res        = '0;
    exec_res.status = cur.status;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur.idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr_en) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[cur.idx] <= 1'b1;
    end
  end

  always_comb begin
    set_acc   = sel ? held.nz : held.all;
    areq.cnt  = set_acc.cnt;
    areq.sum  = set_acc.sum;
    areq.sq   = set_acc.sq;
    areq.start = 1'b0;
    areq.sigma = 1'b0;
    set_done  = 1'b0;
    set_mean  = mean_v[sel];
    set_sig   = sig_v[sel];
    unique case (state)
      B_SET: begin
        if (set_acc.cnt == '0) begin
          set_done = 1'b1;
          set_mean = '0;
          set_sig  = '0;
        end else begin
          areq.start = 1'b1;
        end
      end
      B_MEAN: begin
        if (arsp.done) begin
          set_mean = arsp.value;
          if (set_acc.cnt == 25'd1) begin
            set_done = 1'b1;
            set_sig  = rls_pkg::SIG_SAT;
          end else begin
            areq.start = 1'b1;
            areq.sigma = 1'b1;
          end
        end
      end
      B_SIG: begin
        if (arsp.done) begin
          set_done = 1'b1;
          set_sig  = arsp.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_EXEC) begin
      held <= rec;
    end
    if ((state == B_MEAN && arsp.done) || set_done) begin
      mean_v[sel] <= set_mean;
    end
    if (set_done) begin
      sig_v[sel] <= set_sig;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EXEC) begin
      out_res <= exec_res;
    end else if (set_done && sel) begin
      out_res.status          <= (held.all.cnt == '0) ? rls_pkg::ST_EMPTY : rls_pkg::ST_OK;
      out_res.voxel_count     <= held.all.cnt;
      out_res.mean_value      <= 24'(mean_v[0]);
      out_res.std_dev         <= sig_v[0];
      out_res.minimum         <= held.all.mn;
      out_res.maximum         <= held.all.mx;
      out_res.nonzero_count   <= held.nz.cnt;
      out_res.nonzero_sum     <= held.nz.sum;
      out_res.nonzero_mean    <= 24'(set_mean);
      out_res.nonzero_std_dev <= set_sig;
      out_res.nonzero_minimum <= held.nz.mn;
      out_res.nonzero_maximum <= held.nz.mx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_pop) state <= B_EXEC;
        end
        B_EXEC: begin
          sel <= 1'b0;
          if (cur.kind == rls_pkg::K_READ) begin
            state <= B_SET;
          end else begin
            state     <= B_IDLE;
            out_valid <= 1'b1;
          end
        end
        B_SET, B_MEAN, B_SIG: begin
          if (set_done) begin
            if (sel) begin
              state     <= B_IDLE;
              out_valid <= 1'b1;
            end else begin
              sel   <= 1'b1;
              state <= B_SET;
            end
          end else if (areq.start) begin
            state <= areq.sigma ? B_SIG : B_MEAN;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == B_IDLE) && !out_valid)
    else $error("command taken while busy");

  a_wr_clr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !clr_en && (cur.kind == rls_pkg::K_ACC))
    else $error("store write collides with clear");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    arsp.done |-> (state == B_MEAN) || (state == B_SIG))
    else $error("arithmetic result with nobody waiting");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == B_EXEC) || $past(set_done && sel))
    else $error("result raised outside command completion");

endmodule

// ===== rtl/region_label_statistics.sv =====
// ----------------------------------------------------------------------------
// region_label_statistics
// per-region masked statistics: count, mean, deviation, min and max
// ----------------------------------------------------------------------------
// clear, accumulate and error items: the queued command reads its region store entry, then
//   executes and registers its result; the next item leaves the queue only once that result
//   has been taken, and the front queue holds up to two items meanwhile
// read items: when both sets hold two or more samples, the result waits on the shared shift-add
//   multiply, restoring divide and square root unit, run for the mean and deviation of each set
// reset: synchronous; all regions read as empty at once, region_count 256
module region_label_statistics (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], region_label[10:2], sample[26:11]
  input  logic [31:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, voxel_count, mean_value, std_dev, minimum, maximum, nonzero_count,
  // nonzero_sum, nonzero_mean, nonzero_std_dev, nonzero_minimum, nonzero_maximum
  output logic [255:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data
);

  logic             q_valid;
  rls_pkg::cmd_t    q_cmd;
  logic             q_pop;
  rls_pkg::result_t res;

  assign cfg_ready = 1'b1;

  rls_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .opcode       (s_axis_tdata[1:0]),
    .region_label (s_axis_tdata[10:2]),
    .sample       (s_axis_tdata[26:11]),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  rls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule
